FILE: sv/rbs_pkg.sv
// Shared types and constants for the ray/box slab intersection pipeline.
package rbs_pkg;

  localparam int unsigned QShift   = 16;
  localparam int unsigned NearZero = 64;
  localparam int unsigned DistW    = 31;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned DiffW    = CoordW + 1;
  localparam int unsigned DivNumW  = DiffW + QShift;
  localparam int unsigned DivDenW  = CoordW;
  localparam int unsigned TW       = DivNumW + 1;
  localparam int unsigned DivLat   = DivNumW;
  localparam int unsigned PipeLen  = 2 + DivLat + 6;
  localparam logic [DistW-1:0] MaxDistReset = {DistW{1'b1}};

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
  } ray_in_t;

  typedef struct packed {
    logic                     hit;
    logic [DistW-1:0]         entry_distance;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
  } ray_out_t;

endpackage

FILE: sv/rbs_div_pipe.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module rbs_div_pipe (
  input  logic                        clk_i,
  input  logic [rbs_pkg::DivNumW-1:0] num_i,
  input  logic [rbs_pkg::DivDenW-1:0] den_i,
  output logic [rbs_pkg::DivNumW-1:0] quo_o
);
  import rbs_pkg::*;

  logic [DivDenW-1:0] rem_in  [DivNumW];
  logic [DivNumW-1:0] num_in  [DivNumW];
  logic [DivDenW-1:0] den_in  [DivNumW];
  logic [DivNumW-1:0] quo_in  [DivNumW];
  logic [DivDenW-1:0] rem_q   [DivNumW];
  logic [DivNumW-1:0] quo_q   [DivNumW];

  assign rem_in[0] = '0;
  assign num_in[0] = num_i;
  assign den_in[0] = den_i;
  assign quo_in[0] = '0;

  for (genvar k = 0; k < DivNumW; k++) begin : g_stage
    logic [DivDenW:0] trial;
    logic [DivDenW:0] diff;
    logic             ge;

    assign trial = {rem_in[k], num_in[k][DivNumW-1]};
    assign diff  = trial - {1'b0, den_in[k]};
    assign ge    = trial >= {1'b0, den_in[k]};

    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
      quo_q[k] <= {quo_in[k][DivNumW-2:0], ge};
    end

    if (k < DivNumW - 1) begin : g_fwd
      logic [DivNumW-1:0] num_q;
      logic [DivDenW-1:0] den_q;
      always_ff @(posedge clk_i) begin
        num_q <= {num_in[k][DivNumW-2:0], 1'b0};
        den_q <= den_in[k];
      end
      assign rem_in[k+1] = rem_q[k];
      assign num_in[k+1] = num_q;
      assign den_in[k+1] = den_q;
      assign quo_in[k+1] = quo_q[k];
    end
  end

  assign quo_o = quo_q[DivNumW-1];

endmodule

FILE: sv/ray_box_slab_intersect_top.sv
// Ray against axis-aligned box slab test, fully pipelined, one item per cycle.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------
//  request  | start / busy        | req_i  (rbs_pkg::ray_in_t)
//  result   | done_o (strobe)     | res_o  (rbs_pkg::ray_out_t)
//  config   | cfg_we_i            | cfg_wdata_i (max_distance)
//
// An item may start every cycle; busy is always low.
// The result strobes once an item has passed the six 49-stage
// dividers (one quotient bit per stage) plus eight stages around them.
// Reset clears the valid bits and sets max_distance to its full range.
// The receiver cannot stall, so the pipeline advances every cycle.
module ray_box_slab_intersect_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rbs_pkg::ray_in_t               req_i,
  output logic                           done_o,
  output rbs_pkg::ray_out_t              res_o,
  input  logic                           cfg_we_i,
  input  logic [rbs_pkg::DistW-1:0]      cfg_wdata_i
);
  import rbs_pkg::*;

  typedef struct packed {
    logic [2:0]                    near;
    logic [2:0]                    in_slab;
    logic [2:0][CoordW-1:0]        dir;
    logic [2:0][CoordW-1:0]        org;
  } side_t;

  logic [DistW-1:0]   max_dist_q;
  logic [PipeLen-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MaxDistReset;
      vld_q      <= '0;
    end else begin
      if (cfg_we_i) max_dist_q <= cfg_wdata_i;
      vld_q <= {vld_q[PipeLen-2:0], start};
    end
  end

  assign busy   = 1'b0;
  assign done_o = vld_q[PipeLen-1];

  // Stage 0: input register.
  logic signed [CoordW-1:0] org_q [3];
  logic signed [CoordW-1:0] dir_q [3];
  logic signed [CoordW-1:0] lo_q  [3];
  logic signed [CoordW-1:0] hi_q  [3];

  always_ff @(posedge clk_i) begin
    org_q[0] <= req_i.origin_x;  org_q[1] <= req_i.origin_y;  org_q[2] <= req_i.origin_z;
    dir_q[0] <= req_i.dir_x;     dir_q[1] <= req_i.dir_y;     dir_q[2] <= req_i.dir_z;
    lo_q[0]  <= req_i.box_min_x; lo_q[1]  <= req_i.box_min_y; lo_q[2]  <= req_i.box_min_z;
    hi_q[0]  <= req_i.box_max_x; hi_q[1]  <= req_i.box_max_y; hi_q[2]  <= req_i.box_max_z;
  end

  // Stage 1: slab offsets as sign and magnitude for the dividers.
  logic [DivNumW-1:0] num_q [6];
  logic [DivDenW-1:0] den_q [6];
  logic [5:0]         neg_q;
  side_t              side1_q;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      logic signed [DiffW-1:0] dlo, dhi;
      logic [DiffW-1:0]        mlo, mhi;
      logic [DivDenW-1:0]      mden;
      dlo  = DiffW'(lo_q[a]) - DiffW'(org_q[a]);
      dhi  = DiffW'(hi_q[a]) - DiffW'(org_q[a]);
      mlo  = dlo[DiffW-1] ? DiffW'(-dlo) : DiffW'(dlo);
      mhi  = dhi[DiffW-1] ? DiffW'(-dhi) : DiffW'(dhi);
      mden = dir_q[a][CoordW-1] ? DivDenW'(-dir_q[a]) : DivDenW'(dir_q[a]);
      num_q[2*a]   <= {mlo, {QShift{1'b0}}};
      num_q[2*a+1] <= {mhi, {QShift{1'b0}}};
      den_q[2*a]   <= mden;
      den_q[2*a+1] <= mden;
      neg_q[2*a]   <= dlo[DiffW-1] ^ dir_q[a][CoordW-1];
      neg_q[2*a+1] <= dhi[DiffW-1] ^ dir_q[a][CoordW-1];
      side1_q.near[a]    <= (dir_q[a] >= -$signed(CoordW'(NearZero))) &&
                            (dir_q[a] <= $signed(CoordW'(NearZero)));
      side1_q.in_slab[a] <= (org_q[a] >= lo_q[a]) && (org_q[a] <= hi_q[a]);
      side1_q.dir[a]     <= dir_q[a];
      side1_q.org[a]     <= org_q[a];
    end
  end

  logic [DivNumW-1:0] quo [6];
  for (genvar j = 0; j < 6; j++) begin : g_div
    rbs_div_pipe u_div (
      .clk_i (clk_i),
      .num_i (num_q[j]),
      .den_i (den_q[j]),
      .quo_o (quo[j])
    );
  end

  // Delay the side data and quotient signs alongside the dividers.
  side_t      side_dly_q [DivLat];
  logic [5:0] neg_dly_q  [DivLat];

  always_ff @(posedge clk_i) begin
    side_dly_q[0] <= side1_q;
    neg_dly_q[0]  <= neg_q;
    for (int i = 1; i < DivLat; i++) begin
      side_dly_q[i] <= side_dly_q[i-1];
      neg_dly_q[i]  <= neg_dly_q[i-1];
    end
  end

  // P1: apply quotient sign.
  logic signed [TW-1:0] t_q [6];
  side_t                side_p1_q;
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 6; j++) begin
      t_q[j] <= neg_dly_q[DivLat-1][j] ? -$signed({1'b0, quo[j]}) : $signed({1'b0, quo[j]});
    end
    side_p1_q <= side_dly_q[DivLat-1];
  end

  // P2: order entry and exit per axis.
  logic signed [TW-1:0] tmin_q [3];
  logic signed [TW-1:0] tmax_q [3];
  side_t                side_p2_q;
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (t_q[2*a] > t_q[2*a+1]) begin
        tmin_q[a] <= t_q[2*a+1];
        tmax_q[a] <= t_q[2*a];
      end else begin
        tmin_q[a] <= t_q[2*a];
        tmax_q[a] <= t_q[2*a+1];
      end
    end
    side_p2_q <= side_p1_q;
  end

  // P3: narrow the interval over the non-degenerate axes.
  logic signed [TW-1:0] tnear_q, tfar_q;
  side_t                side_p3_q;
  always_ff @(posedge clk_i) begin
    logic signed [TW-1:0] tn, tf;
    tn = '0;
    tf = $signed(TW'(max_dist_q));
    for (int a = 0; a < 3; a++) begin
      if (!side_p2_q.near[a]) begin
        if (tmin_q[a] > tn) tn = tmin_q[a];
        if (tmax_q[a] < tf) tf = tmax_q[a];
      end
    end
    tnear_q   <= tn;
    tfar_q    <= tf;
    side_p3_q <= side_p2_q;
  end

  // P4: hit decision.
  logic             hit_p4_q;
  logic [DistW-1:0] entry_p4_q;
  side_t            side_p4_q;
  always_ff @(posedge clk_i) begin
    logic h;
    h = (&(side_p3_q.in_slab | ~side_p3_q.near)) && (tnear_q <= tfar_q);
    hit_p4_q   <= h;
    entry_p4_q <= h ? tnear_q[DistW-1:0] : '0;
    side_p4_q  <= side_p3_q;
  end

  // P5: dir * entry.
  logic signed [2*CoordW-1:0] prod_q [3];
  logic signed [CoordW-1:0]   org_p5_q [3];
  logic                       hit_p5_q;
  logic [DistW-1:0]           entry_p5_q;
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      prod_q[a]   <= $signed(side_p4_q.dir[a]) * $signed({1'b0, entry_p4_q});
      org_p5_q[a] <= side_p4_q.org[a];
    end
    hit_p5_q   <= hit_p4_q;
    entry_p5_q <= entry_p4_q;
  end

  // P6: floor shift, add origin, saturate, zero on miss.
  logic signed [CoordW-1:0] pt [3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [2*CoordW-QShift-1:0] sh;
      logic signed [2*CoordW-QShift:0]   sum;
      sh  = prod_q[a][2*CoordW-1:QShift];
      sum = (2*CoordW-QShift+1)'(sh) + (2*CoordW-QShift+1)'(org_p5_q[a]);
      if (sum > $signed((2*CoordW-QShift+1)'({1'b0, {(CoordW-1){1'b1}}})))
        pt[a] = {1'b0, {(CoordW-1){1'b1}}};
      else if (sum < -$signed((2*CoordW-QShift+1)'({1'b1, {(CoordW-1){1'b0}}})))
        pt[a] = {1'b1, {(CoordW-1){1'b0}}};
      else
        pt[a] = sum[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    res_o.hit            <= hit_p5_q;
    res_o.entry_distance <= entry_p5_q;
    res_o.point_x        <= hit_p5_q ? pt[0] : '0;
    res_o.point_y        <= hit_p5_q ? pt[1] : '0;
    res_o.point_z        <= hit_p5_q ? pt[2] : '0;
  end

endmodule
